/* hdl/wildcard_pattern_matcher_defines.svh */
// Assertion macros for the checker file of the wildcard matcher.
`ifndef WILDCARD_PATTERN_MATCHER_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define WPM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define WPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/wpm_pkg.sv */
`default_nettype none

package wpm_pkg;

   // Store sizes and character width.
   localparam int PATTERN_DEPTH = 64;
   localparam int SUBJECT_DEPTH = 256;
   localparam int CHAR_BITS     = 16;

   // Length counters hold the depth itself; addresses only index the depth.
   localparam int PLEN_W  = $clog2(PATTERN_DEPTH + 1);
   localparam int SLEN_W  = $clog2(SUBJECT_DEPTH + 1);
   localparam int PADDR_W = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
   localparam int SADDR_W = (SUBJECT_DEPTH > 1) ? $clog2(SUBJECT_DEPTH) : 1;

   // Wildcard codes.
   localparam logic [CHAR_BITS-1:0] STAR_CODE  = CHAR_BITS'(42);
   localparam logic [CHAR_BITS-1:0] QUEST_CODE = CHAR_BITS'(63);

   // Command codes.
   localparam logic [1:0] CMD_PAT = 2'd0;
   localparam logic [1:0] CMD_SUB = 2'd1;
   localparam logic [1:0] CMD_RUN = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] ch;
   } req_type;

   typedef struct packed {
      logic matched;
      logic overflowed;
   } rsp_type;

   // Start request from the store control to the match engine.
   typedef struct packed {
      logic              start;
      logic [PLEN_W-1:0] pat_len;
      logic [SLEN_W-1:0] sub_len;
      logic              overflow;
   } eng_cmd_type;

   // Masks or extends the 16-bit input character to CHAR_BITS bits.
   function automatic logic [CHAR_BITS-1:0] to_char(input logic [15:0] ch);
      logic [31:0] wide;
      wide = 32'(ch);
      return wide[CHAR_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

/* hdl/wpm_ram.sv */
`default_nettype none

module wpm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [AW-1:0]            wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [AW-1:0]            rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/wpm_engine.sv */
`default_nettype none

module wpm_engine
   import wpm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire eng_cmd_type          eng_cmd,
   output logic                      busy,
   output logic      [PADDR_W-1:0]   pat_addr,
   input  wire logic [CHAR_BITS-1:0] pat_char,
   output logic      [SADDR_W-1:0]   sub_addr,
   input  wire logic [CHAR_BITS-1:0] sub_char,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [PLEN_W-1:0] pi_ff, pi_in, mark_p_ff, mark_p_in, plen_ff;
   logic [SLEN_W-1:0] si_ff, si_in, mark_s_ff, mark_s_in, slen_ff;
   logic              have_mark_ff, have_mark_in;
   logic              ovf_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              p_ok, s_ok, is_star, hit, finish, result;
   logic [PLEN_W-1:0] pi_inc;
   logic [SLEN_W-1:0] si_inc;

   // Compare the characters at the current indexes.
   assign p_ok    = pi_ff < plen_ff;
   assign s_ok    = si_ff < slen_ff;
   assign is_star = p_ok && (pat_char == STAR_CODE);
   assign hit     = p_ok && ((pat_char == sub_char) || (pat_char == QUEST_CODE));
   assign pi_inc  = pi_ff + 1'b1;
   assign si_inc  = si_ff + 1'b1;

   // One step of the greedy match with a single backtrack point.
   always_comb begin
      state_in     = state_ff;
      pi_in        = pi_ff;
      si_in        = si_ff;
      mark_p_in    = mark_p_ff;
      mark_s_in    = mark_s_ff;
      have_mark_in = have_mark_ff;
      finish       = 1'b0;
      result       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (eng_cmd.start) begin
               state_in     = ST_FETCH;
               pi_in        = '0;
               si_in        = '0;
               have_mark_in = 1'b0;
            end
         end
         ST_FETCH: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (s_ok) begin
               if (is_star) begin
                  pi_in        = pi_inc;
                  mark_p_in    = pi_inc;
                  mark_s_in    = si_inc;
                  have_mark_in = 1'b1;
                  if (pi_inc == plen_ff) begin
                     finish = 1'b1;
                     result = 1'b1;
                  end
               end else if (hit) begin
                  pi_in = pi_inc;
                  si_in = si_inc;
               end else if (!have_mark_ff) begin
                  finish = 1'b1;
               end else begin
                  pi_in     = mark_p_ff;
                  si_in     = mark_s_ff;
                  mark_s_in = mark_s_ff + 1'b1;
               end
            end else if (is_star) begin
               // Trailing stars match the empty rest of the subject.
               pi_in = pi_inc;
            end else begin
               finish = 1'b1;
               result = (pi_ff == plen_ff);
            end
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // In the evaluate state the next indexes go straight to the stores, so
   // the data for the following step arrives in the next cycle.
   assign pat_addr = (state_ff == ST_EVAL) ? pi_in[PADDR_W-1:0] : pi_ff[PADDR_W-1:0];
   assign sub_addr = (state_ff == ST_EVAL) ? si_in[SADDR_W-1:0] : si_ff[SADDR_W-1:0];

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Index, mark and result registers.
   always_ff @(posedge clock) begin
      pi_ff        <= pi_in;
      si_ff        <= si_in;
      mark_p_ff    <= mark_p_in;
      mark_s_ff    <= mark_s_in;
      have_mark_ff <= have_mark_in;
      if (eng_cmd.start && (state_ff == ST_IDLE)) begin
         plen_ff <= eng_cmd.pat_len;
         slen_ff <= eng_cmd.sub_len;
         ovf_ff  <= eng_cmd.overflow;
      end
      if (finish) begin
         rsp_ff.matched    <= result;
         rsp_ff.overflowed <= ovf_ff;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* hdl/wildcard_pattern_matcher.sv */
// Append items (pattern or subject character) can be taken back to back.
// A run item's result is registered after a fetch state and N compare
// steps (one per cycle, at least one, bounded by about plen * slen with
// backtracking); the single store read port per step sets the step rate.
// No item is taken while a match runs, nor a run while a result waits.
// Reset clears the lengths, the overflow flag and the result valid; not stores.
`default_nettype none

module wildcard_pattern_matcher
   import wpm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic [PLEN_W-1:0]    pat_len_ff, pat_len_in;
   logic [SLEN_W-1:0]    sub_len_ff, sub_len_in;
   logic                 ovf_ff, ovf_in;
   logic                 accept, pat_full, sub_full, pat_we, sub_we;
   logic                 eng_busy;
   eng_cmd_type          eng_cmd;
   logic [PADDR_W-1:0]   pat_addr;
   logic [SADDR_W-1:0]   sub_addr;
   logic [CHAR_BITS-1:0] pat_char, sub_char, wr_char;

   // Stores are locked while the engine reads them, which keeps appends off
   // entries that are in use.
   assign req_stall = eng_busy || (rsp_valid && (req_data.cmd == CMD_RUN));
   assign accept    = req_valid && !req_stall;
   assign pat_full  = (pat_len_ff == PLEN_W'(PATTERN_DEPTH));
   assign sub_full  = (sub_len_ff == SLEN_W'(SUBJECT_DEPTH));
   assign wr_char   = to_char(req_data.ch);

   // Decode the accepted item.
   always_comb begin
      pat_len_in = pat_len_ff;
      sub_len_in = sub_len_ff;
      ovf_in     = ovf_ff;
      pat_we     = 1'b0;
      sub_we     = 1'b0;
      eng_cmd    = '{start: 1'b0, pat_len: pat_len_ff, sub_len: sub_len_ff,
                     overflow: ovf_ff};
      if (accept) begin
         unique case (req_data.cmd)
            CMD_PAT: begin
               if (pat_full) begin
                  ovf_in = 1'b1;
               end else begin
                  pat_we     = 1'b1;
                  pat_len_in = pat_len_ff + 1'b1;
               end
            end
            CMD_SUB: begin
               if (sub_full) begin
                  ovf_in = 1'b1;
               end else begin
                  sub_we     = 1'b1;
                  sub_len_in = sub_len_ff + 1'b1;
               end
            end
            CMD_RUN: begin
               eng_cmd.start = 1'b1;
               pat_len_in    = '0;
               sub_len_in    = '0;
               ovf_in        = 1'b0;
            end
            default: begin
               // The unused command changes nothing.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff <= '0;
         sub_len_ff <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         pat_len_ff <= pat_len_in;
         sub_len_ff <= sub_len_in;
         ovf_ff     <= ovf_in;
      end
   end

   wpm_ram #(
      .WIDTH (CHAR_BITS),
      .DEPTH (PATTERN_DEPTH)
   ) u_pat_ram (
      .clock   (clock),
      .wr_en   (pat_we),
      .wr_addr (pat_len_ff[PADDR_W-1:0]),
      .wr_data (wr_char),
      .rd_addr (pat_addr),
      .rd_data (pat_char)
   );

   wpm_ram #(
      .WIDTH (CHAR_BITS),
      .DEPTH (SUBJECT_DEPTH)
   ) u_sub_ram (
      .clock   (clock),
      .wr_en   (sub_we),
      .wr_addr (sub_len_ff[SADDR_W-1:0]),
      .wr_data (wr_char),
      .rd_addr (sub_addr),
      .rd_data (sub_char)
   );

   wpm_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .eng_cmd   (eng_cmd),
      .busy      (eng_busy),
      .pat_addr  (pat_addr),
      .pat_char  (pat_char),
      .sub_addr  (sub_addr),
      .sub_char  (sub_char),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* hdl/wpm_checker.sv */
`default_nettype none
`include "wildcard_pattern_matcher_defines.svh"

module wpm_checker
   import wpm_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // A run item keeps the input locked while the match is in progress.
   `WPM_ASSERT_NEXT(a_run_locks_input, clock, reset, req_valid && !req_stall && (req_data.cmd == CMD_RUN), req_stall, "input not locked after run item")

   // A new run is held off while a result is still waiting.
   `WPM_ASSERT_IMPLY(a_run_waits_result, clock, reset, rsp_valid && req_valid && (req_data.cmd == CMD_RUN), req_stall, "run taken while result pending")

   // Each run gives one result, so a taken result is not followed at once.
   `WPM_ASSERT_NEXT(a_single_result, clock, reset, rsp_valid && !rsp_stall, !rsp_valid, "result repeated")

   // A stalled result holds.
   `WPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind wildcard_pattern_matcher wpm_checker u_checker (.*);

`default_nettype wire
